/* rtl/core/assert_macros.svh */
// Assertion helpers used by the execute unit core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EVU_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("execute unit assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define EVU_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("execute unit assertion failed");

`endif

/* rtl/core/evu_pkg.sv */
`default_nettype none
package evu_pkg;

    localparam int WORD_W          = 32;
    localparam int OP_W            = 6;
    localparam int CNT_W           = 4;
    localparam int SRC_SLOTS       = 8;
    localparam int DEF_MAX_SOURCES = 8;
    localparam int DIV_STAGES      = WORD_W;
    localparam int MUL_STAGES      = 4;
    localparam int HALF_W          = WORD_W / 2;

    localparam logic [WORD_W-1:0] INT_MIN  = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

    localparam logic CFG_DIV_ZERO = 1'b0;
    localparam logic CFG_DIV_OVF  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ZDIV    = 3'd1,
        ST_OVF     = 3'd2,
        ST_BADOPD  = 3'd3,
        ST_EXIT    = 3'd4,
        ST_UNKNOWN = 3'd5
    } status_t;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 6'd0, OP_SUB = 6'd1, OP_MUL = 6'd2, OP_DIV = 6'd3,
        OP_DIV_U = 6'd4, OP_REM = 6'd5, OP_REM_U = 6'd6, OP_LONG_MUL = 6'd7,
        OP_LONG_MUL_U = 6'd8, OP_AND2 = 6'd9, OP_OR2 = 6'd10, OP_VAND = 6'd11,
        OP_VOR = 6'd12, OP_BIT_AND = 6'd13, OP_BIT_OR = 6'd14, OP_BIT_XOR = 6'd15,
        OP_INV = 6'd16, OP_L_SHIFT = 6'd17, OP_R_SHIFT_U = 6'd18, OP_R_SHIFT = 6'd19,
        OP_TST_EQ = 6'd20, OP_TST_NE = 6'd21, OP_TST_GT = 6'd22, OP_TST_GE = 6'd23,
        OP_TST_GT_U = 6'd24, OP_TST_GE_U = 6'd25, OP_BR = 6'd26, OP_BR_LNK = 6'd27,
        OP_BR_EQ = 6'd28, OP_BR_NE = 6'd29, OP_BR_GT = 6'd30, OP_BR_GE = 6'd31,
        OP_BR_GT_U = 6'd32, OP_BR_GE_U = 6'd33, OP_JMP = 6'd34, OP_JMP_LNK = 6'd35,
        OP_MOV_EQ = 6'd36, OP_MOV_GT = 6'd37, OP_MOV_GE = 6'd38, OP_MOV_GT_U = 6'd39,
        OP_MOV_GE_U = 6'd40, OP_MOV = 6'd41, OP_LD_B_U = 6'd42, OP_LD_H_U = 6'd43,
        OP_ST_B = 6'd44, OP_ST_H = 6'd45, OP_LD_B = 6'd46, OP_LD_H = 6'd47,
        OP_NEG = 6'd48, OP_EXIT = 6'd49, OP_ABS = 6'd50, OP_VMAX = 6'd51,
        OP_VMIN = 6'd52, OP_NOT = 6'd53, OP_BOOL = 6'd54, OP_NOP = 6'd55
    } op_t;

    typedef enum logic [1:0] {
        VS_AND = 2'd0,
        VS_OR  = 2'd1,
        VS_MAX = 2'd2,
        VS_MIN = 2'd3
    } vsel_t;

    typedef struct packed {
        logic              in_range;
        logic              is_last;
        logic              is_zero;
        logic [WORD_W-1:0] value;
    } lane_t;

    typedef struct packed {
        logic              use_div;
        logic              use_mul;
        logic              mul_hi;
        logic              is_rem;
        logic              negate;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] npc;
        status_t           st;
        logic [WORD_W-1:0] rc;
    } side_t;

endpackage
`default_nettype wire

/* rtl/core/evu_lane.sv */
`default_nettype none
module evu_lane
    import evu_pkg::*;
#(
    parameter int LANE_IDX = 0
) (
    input  wire logic [WORD_W-1:0] src,
    input  wire logic [WORD_W-1:0] first,
    input  wire logic [CNT_W-1:0]  cnt,
    output lane_t                  lane
);

    always_comb
    begin
        lane.in_range = cnt > CNT_W'(LANE_IDX);
        lane.is_last  = cnt == CNT_W'(LANE_IDX + 1);
        lane.is_zero  = src == '0;
        // out-of-range lanes repeat the first operand so max/min ignore them
        lane.value    = lane.in_range ? src : first;
    end

endmodule
`default_nettype wire

/* rtl/core/evu_merge.sv */
`default_nettype none
module evu_merge
    import evu_pkg::*;
#(
    parameter int NUM_LANES = DEF_MAX_SOURCES
) (
    input  wire lane_t             lanes [NUM_LANES],
    input  wire vsel_t             sel,
    output logic [WORD_W-1:0]      result
);

    localparam int LEAVES = SRC_SLOTS;

    logic [WORD_W-1:0] lvl0 [LEAVES];
    logic [WORD_W-1:0] lvl1 [LEAVES/2];
    logic [WORD_W-1:0] lvl2 [LEAVES/4];
    logic [WORD_W-1:0] ext;
    logic              any_zero;
    logic [WORD_W-1:0] last_val;
    logic [WORD_W-1:0] first_nz;
    logic              is_max;

    function automatic logic [WORD_W-1:0] pick(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b,
                                               input logic              mx);
        logic gt;
        gt = $signed(a) > $signed(b);
        return (gt == mx) ? a : b;
    endfunction

    always_comb
    begin
        is_max = sel == VS_MAX;
        for (int i = 0; i < LEAVES; i++)
        begin
            lvl0[i] = (i < NUM_LANES) ? lanes[i].value : lanes[0].value;
        end
        for (int i = 0; i < LEAVES/2; i++)
        begin
            lvl1[i] = pick(lvl0[2*i], lvl0[2*i+1], is_max);
        end
        for (int i = 0; i < LEAVES/4; i++)
        begin
            lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1], is_max);
        end
        ext = pick(lvl2[0], lvl2[1], is_max);

        any_zero = 1'b0;
        last_val = '0;
        first_nz = '0;
        for (int i = NUM_LANES - 1; i >= 0; i--)
        begin
            if (lanes[i].in_range && lanes[i].is_zero)
                any_zero = 1'b1;
            if (lanes[i].is_last)
                last_val = lanes[i].value;
            if (lanes[i].in_range && !lanes[i].is_zero)
                first_nz = lanes[i].value;
        end

        case (sel)
            VS_AND:  result = any_zero ? '0 : last_val;
            VS_OR:   result = first_nz;
            default: result = ext;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/evu_mul.sv */
`default_nettype none
module evu_mul
    import evu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [WORD_W-1:0] a,
    input  wire logic [WORD_W-1:0] b,
    input  wire logic              is_signed,
    output logic [WORD_W-1:0]      lo,
    output logic [WORD_W-1:0]      hi
);

    logic [WORD_W-1:0]   ll_reg, lh_reg, hl_reg, hh_reg, corr1_reg;
    logic [WORD_W-1:0]   ll2_reg, hh2_reg, corr2_reg, corr3_reg;
    logic [WORD_W:0]     mid_reg;
    logic [2*WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0]   lo_reg, hi_reg;
    logic [WORD_W-1:0]   corr_next;

    // signed high half = unsigned high half minus the cross terms of the signs
    always_comb
    begin
        corr_next = ((is_signed && a[WORD_W-1]) ? b : '0)
                  + ((is_signed && b[WORD_W-1]) ? a : '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg    <= WORD_W'(a[HALF_W-1:0]) * WORD_W'(b[HALF_W-1:0]);
            lh_reg    <= WORD_W'(a[HALF_W-1:0]) * WORD_W'(b[WORD_W-1:HALF_W]);
            hl_reg    <= WORD_W'(a[WORD_W-1:HALF_W]) * WORD_W'(b[HALF_W-1:0]);
            hh_reg    <= WORD_W'(a[WORD_W-1:HALF_W]) * WORD_W'(b[WORD_W-1:HALF_W]);
            corr1_reg <= corr_next;
            mid_reg   <= {1'b0, lh_reg} + {1'b0, hl_reg};
            ll2_reg   <= ll_reg;
            hh2_reg   <= hh_reg;
            corr2_reg <= corr1_reg;
            prod_reg  <= {hh2_reg, ll2_reg}
                       + {{(WORD_W-HALF_W-1){1'b0}}, mid_reg, {HALF_W{1'b0}}};
            corr3_reg <= corr2_reg;
            lo_reg    <= prod_reg[WORD_W-1:0];
            hi_reg    <= prod_reg[2*WORD_W-1:WORD_W] - corr3_reg;
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule
`default_nettype wire

/* rtl/core/evu_div.sv */
`default_nettype none
module evu_div
    import evu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [WORD_W-1:0] dividend,
    input  wire logic [WORD_W-1:0] divisor,
    output logic [WORD_W-1:0]      quo,
    output logic [WORD_W-1:0]      rem
);

    // one restoring step per stage; dq shifts the dividend out and the quotient in
    logic [WORD_W-1:0] rem_reg [DIV_STAGES+1];
    logic [WORD_W-1:0] dq_reg  [DIV_STAGES+1];
    logic [WORD_W-1:0] dvs_reg [DIV_STAGES+1];

    always_comb
    begin
        rem_reg[0] = '0;
        dq_reg[0]  = dividend;
        dvs_reg[0] = divisor;
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_step
        logic [WORD_W:0] trial;
        logic [WORD_W:0] diff;
        logic            fits;

        always_comb
        begin
            trial = {rem_reg[k], dq_reg[k][WORD_W-1]};
            diff  = trial - {1'b0, dvs_reg[k]};
            fits  = trial >= {1'b0, dvs_reg[k]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
                dq_reg[k+1]  <= {dq_reg[k][WORD_W-2:0], fits};
                dvs_reg[k+1] <= dvs_reg[k];
            end
        end
    end

    assign quo = dq_reg[DIV_STAGES];
    assign rem = rem_reg[DIV_STAGES];

endmodule
`default_nettype wire

/* rtl/core/vm_instruction_execute_unit_core.sv */
// Execute stage of a 32-bit bytecode machine.
// Request channel: in_valid/in_stall with req_type, src0..src7, src_count and
// current_pc; a request is taken at a clock edge with in_valid high and
// in_stall low. Result channel: out_valid/out_stall with result_low,
// result_high, next_pc, status and exit_code; one result per request, in order.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 = report
// division by zero, 1 = report signed overflow); write only while idle.
// Pipeline: operand register, the 32-stage radix-2 divider (other units are
// delayed to match it) and the result register ahead of out_valid.
// Throughput: one request per cycle unless stalled; units are fully pipelined.
// Variadic AND/OR/MAX/MIN run in MAX_SOURCES parallel lanes plus a merge tree.
// When the result is held by out_stall, the whole pipe freezes and in_stall
// rises in the same cycle; nothing is dropped.
// Reset clears the valid bits and both configuration registers.
`default_nettype none
`include "assert_macros.svh"
module vm_instruction_execute_unit_core
    import evu_pkg::*;
#(
    parameter int MAX_SOURCES = DEF_MAX_SOURCES
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [0:0]               cfg_index,
    input  wire logic [0:0]               cfg_wdata,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [OP_W-1:0]          req_type,
    input  wire logic signed [WORD_W-1:0] src0,
    input  wire logic signed [WORD_W-1:0] src1,
    input  wire logic signed [WORD_W-1:0] src2,
    input  wire logic signed [WORD_W-1:0] src3,
    input  wire logic signed [WORD_W-1:0] src4,
    input  wire logic signed [WORD_W-1:0] src5,
    input  wire logic signed [WORD_W-1:0] src6,
    input  wire logic signed [WORD_W-1:0] src7,
    input  wire logic [CNT_W-1:0]         src_count,
    input  wire logic [WORD_W-1:0]        current_pc,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [WORD_W-1:0]      result_low,
    output logic signed [WORD_W-1:0]      result_high,
    output logic [WORD_W-1:0]             next_pc,
    output logic [2:0]                    status,
    output logic signed [WORD_W-1:0]      exit_code
);

    localparam int MDLY = DIV_STAGES - MUL_STAGES;

    logic adv;

    // configuration
    logic dz_en_reg, ovf_en_reg;

    // operand stage
    logic              s1_valid_reg;
    logic [OP_W-1:0]   s1_op_reg;
    logic [WORD_W-1:0] s1_src_reg [SRC_SLOTS];
    logic [CNT_W-1:0]  s1_cnt_reg;
    logic [WORD_W-1:0] s1_pc_reg;

    // decode results
    side_t             side_next;
    logic [WORD_W-1:0] div_a, div_b;
    logic              mul_signed;
    vsel_t             vsel;
    logic [WORD_W-1:0] var_result;
    lane_t             lanes [MAX_SOURCES];

    // alignment pipes
    side_t             side_reg  [DIV_STAGES];
    logic              valid_reg [DIV_STAGES];
    logic [WORD_W-1:0] mlo_reg   [MDLY];
    logic [WORD_W-1:0] mhi_reg   [MDLY];
    logic [WORD_W-1:0] mul_lo, mul_hi, quo, rem;

    // result register
    logic              out_valid_reg;
    logic [WORD_W-1:0] lo_reg, hi_reg, npc_reg, rc_reg;
    status_t           status_reg;
    logic [WORD_W-1:0] lo_next, hi_next, dv;
    side_t             tail;

    // freeze everything while a finished result is held
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_en_reg  <= 1'b0;
            ovf_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_DIV_ZERO)
                dz_en_reg <= cfg_wdata[0];
            if (cfg_index == CFG_DIV_OVF)
                ovf_en_reg <= cfg_wdata[0];
        end
    end

    // capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg     <= req_type;
            s1_src_reg[0] <= src0;
            s1_src_reg[1] <= src1;
            s1_src_reg[2] <= src2;
            s1_src_reg[3] <= src3;
            s1_src_reg[4] <= src4;
            s1_src_reg[5] <= src5;
            s1_src_reg[6] <= src6;
            s1_src_reg[7] <= src7;
            s1_cnt_reg    <= src_count;
            s1_pc_reg     <= current_pc;
        end
    end

    // variadic lanes and merge
    for (genvar i = 0; i < MAX_SOURCES; i++)
    begin : g_lane
        evu_lane #(
            .LANE_IDX (i)
        ) u_lane (
            .src   (s1_src_reg[i]),
            .first (s1_src_reg[0]),
            .cnt   (s1_cnt_reg),
            .lane  (lanes[i])
        );
    end

    evu_merge #(
        .NUM_LANES (MAX_SOURCES)
    ) u_merge (
        .lanes  (lanes),
        .sel    (vsel),
        .result (var_result)
    );

    // decode and simple ALU
    always_comb
    begin
        logic [WORD_W-1:0] a, b, c, d, pc;
        logic              eq, gts, ges, gtu, geu, big;
        op_t               op;

        a   = s1_src_reg[0];
        b   = s1_src_reg[1];
        c   = s1_src_reg[2];
        d   = s1_src_reg[3];
        pc  = s1_pc_reg;
        op  = op_t'(s1_op_reg);
        eq  = a == b;
        gts = $signed(a) > $signed(b);
        ges = $signed(a) >= $signed(b);
        gtu = a > b;
        geu = a >= b;
        big = |b[WORD_W-1:5];

        side_next  = '0;
        side_next.npc = pc;
        side_next.st  = ST_OK;
        div_a      = a;
        div_b      = b;
        mul_signed = 1'b0;
        vsel       = VS_AND;

        unique case (op)
            OP_ADD:     side_next.lo = a + b;
            OP_SUB:     side_next.lo = a - b;
            OP_MUL:
            begin
                side_next.use_mul = 1'b1;
            end
            OP_DIV, OP_REM:
            begin
                side_next.is_rem  = op == OP_REM;
                div_a = a[WORD_W-1] ? ('0 - a) : a;
                div_b = b[WORD_W-1] ? ('0 - b) : b;
                side_next.negate  = (op == OP_REM) ? a[WORD_W-1]
                                                   : (a[WORD_W-1] ^ b[WORD_W-1]);
                if (b == '0)
                begin
                    if (dz_en_reg)
                        side_next.st = ST_ZDIV;
                    else
                        side_next.lo = (op == OP_DIV) ? ALL_ONES : a;
                end
                else if (op == OP_DIV && a == INT_MIN && b == ALL_ONES && ovf_en_reg)
                    side_next.st = ST_OVF;
                else
                    side_next.use_div = 1'b1;
            end
            OP_DIV_U, OP_REM_U:
            begin
                side_next.is_rem = op == OP_REM_U;
                if (b == '0)
                begin
                    if (dz_en_reg)
                        side_next.st = ST_ZDIV;
                    else
                        side_next.lo = (op == OP_DIV_U) ? ALL_ONES : a;
                end
                else
                    side_next.use_div = 1'b1;
            end
            OP_LONG_MUL, OP_LONG_MUL_U:
            begin
                side_next.use_mul = 1'b1;
                side_next.mul_hi  = 1'b1;
                mul_signed        = op == OP_LONG_MUL;
            end
            OP_AND2:    side_next.lo = (a == '0) ? a : b;
            OP_OR2:     side_next.lo = (a != '0) ? a : b;
            OP_VAND, OP_VOR, OP_VMAX, OP_VMIN:
            begin
                case (op)
                    OP_VAND: vsel = VS_AND;
                    OP_VOR:  vsel = VS_OR;
                    OP_VMAX: vsel = VS_MAX;
                    default: vsel = VS_MIN;
                endcase
                if (s1_cnt_reg == '0 || s1_cnt_reg > CNT_W'(MAX_SOURCES))
                    side_next.st = ST_BADOPD;
                else
                    side_next.lo = var_result;
            end
            OP_BIT_AND: side_next.lo = a & b;
            OP_BIT_OR:  side_next.lo = a | b;
            OP_BIT_XOR: side_next.lo = a ^ b;
            OP_INV:     side_next.lo = ~a;
            OP_L_SHIFT:   side_next.lo = big ? '0 : (a << b[4:0]);
            OP_R_SHIFT_U: side_next.lo = big ? '0 : (a >> b[4:0]);
            OP_R_SHIFT:
                side_next.lo = big ? {WORD_W{a[WORD_W-1]}}
                                   : WORD_W'($signed(a) >>> b[4:0]);
            OP_TST_EQ:   side_next.lo = WORD_W'(eq);
            OP_TST_NE:   side_next.lo = WORD_W'(!eq);
            OP_TST_GT:   side_next.lo = WORD_W'(gts);
            OP_TST_GE:   side_next.lo = WORD_W'(ges);
            OP_TST_GT_U: side_next.lo = WORD_W'(gtu);
            OP_TST_GE_U: side_next.lo = WORD_W'(geu);
            OP_BR:       side_next.npc = pc + a;
            OP_BR_LNK:
            begin
                side_next.lo  = pc;
                side_next.npc = pc + a;
            end
            OP_BR_EQ:   if (eq)  side_next.npc = pc + c;
            OP_BR_NE:   if (!eq) side_next.npc = pc + c;
            OP_BR_GT:   if (gts) side_next.npc = pc + c;
            OP_BR_GE:   if (ges) side_next.npc = pc + c;
            OP_BR_GT_U: if (gtu) side_next.npc = pc + c;
            OP_BR_GE_U: if (geu) side_next.npc = pc + c;
            OP_JMP:     side_next.npc = a;
            OP_JMP_LNK:
            begin
                side_next.lo  = pc;
                side_next.npc = a;
            end
            OP_MOV_EQ:   side_next.lo = eq  ? c : d;
            OP_MOV_GT:   side_next.lo = gts ? c : d;
            OP_MOV_GE:   side_next.lo = ges ? c : d;
            OP_MOV_GT_U: side_next.lo = gtu ? c : d;
            OP_MOV_GE_U: side_next.lo = geu ? c : d;
            OP_MOV, OP_LD_B_U, OP_LD_H_U, OP_ST_B, OP_ST_H: side_next.lo = a;
            OP_LD_B:  side_next.lo = {{(WORD_W-8){a[7]}}, a[7:0]};
            OP_LD_H:  side_next.lo = {{(WORD_W-16){a[15]}}, a[15:0]};
            OP_NEG:   side_next.lo = '0 - a;
            OP_EXIT:
            begin
                side_next.st = ST_EXIT;
                side_next.rc = a;
            end
            OP_ABS:   side_next.lo = a[WORD_W-1] ? ('0 - a) : a;
            OP_NOT:   side_next.lo = WORD_W'(a == '0);
            OP_BOOL:  side_next.lo = WORD_W'(a != '0);
            OP_NOP:   side_next.lo = '0;
            default:  side_next.st = ST_UNKNOWN;
        endcase

        // any error drops the target words and the branch
        if (side_next.st != ST_OK)
        begin
            side_next.lo      = '0;
            side_next.npc     = pc;
            side_next.use_div = 1'b0;
            side_next.use_mul = 1'b0;
        end
    end

    evu_div u_div (
        .clk      (clk),
        .en       (adv),
        .dividend (div_a),
        .divisor  (div_b),
        .quo      (quo),
        .rem      (rem)
    );

    evu_mul u_mul (
        .clk       (clk),
        .en        (adv),
        .a         (s1_src_reg[0]),
        .b         (s1_src_reg[1]),
        .is_signed (mul_signed),
        .lo        (mul_lo),
        .hi        (mul_hi)
    );

    // carry sideband alongside the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= s1_valid_reg;
            for (int k = 1; k < DIV_STAGES; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k < DIV_STAGES; k++)
                side_reg[k] <= side_reg[k-1];
            mlo_reg[0] <= mul_lo;
            mhi_reg[0] <= mul_hi;
            for (int k = 1; k < MDLY; k++)
            begin
                mlo_reg[k] <= mlo_reg[k-1];
                mhi_reg[k] <= mhi_reg[k-1];
            end
        end
    end

    // pick the unit that produced the result
    always_comb
    begin
        tail    = side_reg[DIV_STAGES-1];
        dv      = tail.is_rem ? rem : quo;
        lo_next = tail.lo;
        hi_next = '0;
        if (tail.use_div)
            lo_next = tail.negate ? ('0 - dv) : dv;
        else if (tail.use_mul)
        begin
            lo_next = mlo_reg[MDLY-1];
            hi_next = tail.mul_hi ? mhi_reg[MDLY-1] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= valid_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            npc_reg    <= tail.npc;
            status_reg <= tail.st;
            rc_reg     <= tail.rc;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_low  = lo_reg;
    assign result_high = hi_reg;
    assign next_pc     = npc_reg;
    assign status      = status_reg;
    assign exit_code   = rc_reg;

    `EVU_ASSERT_IMPL(a_hold_blocks_input, clk, rst_n, out_valid_reg && out_stall, in_stall)
    `EVU_ASSERT_NEXT(a_request_enters, clk, rst_n, in_valid && !in_stall, s1_valid_reg)
    `EVU_ASSERT_IMPL(a_error_clears_words, clk, rst_n, out_valid_reg && status_reg != ST_OK, lo_reg == '0 && hi_reg == '0)
    `EVU_ASSERT_IMPL(a_exit_code_only_on_exit, clk, rst_n, out_valid_reg && status_reg != ST_EXIT, rc_reg == '0)

endmodule
`default_nettype wire
